// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Every check samples on the rising
// edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every sampled edge.
`define LLFS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the trigger holds, the consequence must hold in the same cycle.
`define LLFS_ASSERT_IMPLY(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/llfs_pkg.sv =====
// ----------------------------------------------------------------------------
// llfs_pkg
// Shared widths, register map, reset values and types of the link-loss
// failsafe supervisor.
// ----------------------------------------------------------------------------
package llfs_pkg;

  localparam int unsigned LOSS_W     = 16;
  localparam int unsigned BUS_W      = 16;
  localparam int unsigned DELAY_W    = 8;
  localparam int unsigned STICK_W    = 12;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Parameter defaults
  localparam int unsigned HANDSET_TIMEOUT_DEF = 50;
  localparam int unsigned TICKS_PER_UNIT_DEF  = 5;
  localparam int unsigned BUS_ERROR_LIMIT_DEF = 100;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_FS_ENABLE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FS_DELAY    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAND_DELAY  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MID_STICK   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FS_THROTTLE = 3'd4;

  // Register reset values
  localparam logic               RST_FS_ENABLE   = 1'b1;
  localparam logic [DELAY_W-1:0] RST_FS_DELAY    = 8'd10;
  localparam logic [DELAY_W-1:0] RST_LAND_DELAY  = 8'd200;
  localparam logic [STICK_W-1:0] RST_MID_STICK   = 12'd1500;
  localparam logic [STICK_W-1:0] RST_FS_THROTTLE = 12'd1200;

  // Arm block mask bit positions
  localparam int unsigned MASK_LINK_LOST = 0;
  localparam int unsigned MASK_UNCAL     = 1;
  localparam int unsigned MASK_CALIB     = 2;
  localparam int unsigned MASK_BUS_ERR   = 3;

  localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

  typedef struct packed {
    logic               failsafe_enable;
    logic [DELAY_W-1:0] loss_delay;
    logic [DELAY_W-1:0] landing_delay;
    logic [STICK_W-1:0] mid_stick;
    logic [STICK_W-1:0] land_throttle;
  } cfg_t;

  typedef struct packed {
    logic             radio_frame_seen;
    logic             handset_frame_seen;
    logic             is_armed;
    logic             accel_present;
    logic             accel_calibrated;
    logic             calibrating;
    logic [BUS_W-1:0] bus_error_count;
  } item_t;

  typedef struct packed {
    logic              radio_available;
    logic              radio_control_mode;
    logic              handset_available;
    logic              handset_control_mode;
    logic              stick_override;
    logic              force_angle_mode;
    logic              force_disarm;
    logic [MASK_W-1:0] arm_block_mask;
    logic              arm_ok;
  } result_t;

  // Saturating increment of a loss counter
  function automatic logic [LOSS_W-1:0] sat_inc(input logic [LOSS_W-1:0] c);
    sat_inc = (c == LOSS_MAX) ? LOSS_MAX : c + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/llfs_cfg.sv =====
// ----------------------------------------------------------------------------
// llfs_cfg
// APB register file holding the failsafe configuration.
// ----------------------------------------------------------------------------
module llfs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [llfs_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [llfs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [llfs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output llfs_pkg::cfg_t                    cfg
);
  import llfs_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[APB_ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_FS_ENABLE:   cfg_nxt.failsafe_enable = pwdata[0];
        REG_FS_DELAY:    cfg_nxt.loss_delay      = pwdata[DELAY_W-1:0];
        REG_LAND_DELAY:  cfg_nxt.landing_delay   = pwdata[DELAY_W-1:0];
        REG_MID_STICK:   cfg_nxt.mid_stick       = pwdata[STICK_W-1:0];
        REG_FS_THROTTLE: cfg_nxt.land_throttle   = pwdata[STICK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.failsafe_enable <= RST_FS_ENABLE;
      cfg_r.loss_delay      <= RST_FS_DELAY;
      cfg_r.landing_delay   <= RST_LAND_DELAY;
      cfg_r.mid_stick       <= RST_MID_STICK;
      cfg_r.land_throttle   <= RST_FS_THROTTLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_FS_ENABLE:   prdata = APB_DATA_W'(cfg_r.failsafe_enable);
      REG_FS_DELAY:    prdata = APB_DATA_W'(cfg_r.loss_delay);
      REG_LAND_DELAY:  prdata = APB_DATA_W'(cfg_r.landing_delay);
      REG_MID_STICK:   prdata = APB_DATA_W'(cfg_r.mid_stick);
      REG_FS_THROTTLE: prdata = APB_DATA_W'(cfg_r.land_throttle);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/llfs_eval.sv =====
// ----------------------------------------------------------------------------
// llfs_eval
// Per-tick evaluation: handset supervisor, radio failsafe and arming gate,
// with the link state registers they update.
// ----------------------------------------------------------------------------
module llfs_eval #(
  parameter int unsigned HANDSET_TIMEOUT_TICKS = llfs_pkg::HANDSET_TIMEOUT_DEF,
  parameter int unsigned TICKS_PER_DELAY_UNIT  = llfs_pkg::TICKS_PER_UNIT_DEF,
  parameter int unsigned BUS_ERROR_LIMIT       = llfs_pkg::BUS_ERROR_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  llfs_pkg::item_t   item,
  input  llfs_pkg::cfg_t    cfg,
  output llfs_pkg::result_t result
);
  import llfs_pkg::*;

  // Largest threshold is TICKS_PER_DELAY_UNIT * (255 + 255)
  localparam int unsigned SUM_W = DELAY_W + 1;
  localparam int unsigned THR_W = $clog2(TICKS_PER_DELAY_UNIT * ((2 ** SUM_W) - 2) + 1);
  localparam int unsigned CMP_W = (THR_W > LOSS_W) ? THR_W : LOSS_W;
  localparam logic [CMP_W-1:0]  TPD      = CMP_W'(TICKS_PER_DELAY_UNIT);
  localparam logic [LOSS_W-1:0] HS_LIMIT = LOSS_W'(HANDSET_TIMEOUT_TICKS);
  localparam logic [BUS_W-1:0]  BUS_LIM  = BUS_W'(BUS_ERROR_LIMIT);

  logic [LOSS_W-1:0] radio_cnt_r, radio_cnt_nxt;
  logic [LOSS_W-1:0] hs_cnt_r, hs_cnt_nxt;
  logic radio_alive_r, radio_alive_nxt;
  logic radio_mode_r, radio_mode_nxt;
  logic hs_alive_r, hs_alive_nxt;
  logic hs_mode_r, hs_mode_nxt;
  logic link_block_r, link_block_nxt;

  logic [LOSS_W-1:0] radio_cnt0, hs_cnt0;
  logic [SUM_W-1:0]  delay_sum;
  logic [CMP_W-1:0]  t_lost, t_land;
  logic              paused, ovr, angle, disarm;
  logic [MASK_W-1:0] mask;

  assign delay_sum = SUM_W'(cfg.loss_delay) + SUM_W'(cfg.landing_delay);
  assign t_lost    = TPD * CMP_W'(cfg.loss_delay);
  assign t_land    = TPD * CMP_W'(delay_sum);

  always_comb begin
    radio_cnt0 = item.radio_frame_seen   ? '0 : radio_cnt_r;
    hs_cnt0    = item.handset_frame_seen ? '0 : hs_cnt_r;

    radio_alive_nxt = radio_alive_r;
    radio_mode_nxt  = radio_mode_r;
    hs_alive_nxt    = hs_alive_r;
    hs_mode_nxt     = hs_mode_r;
    link_block_nxt  = link_block_r;
    paused          = 1'b0;
    ovr             = 1'b0;
    angle           = 1'b0;
    disarm          = 1'b0;

    // Handset supervisor
    if (hs_cnt0 > HS_LIMIT) begin
      hs_alive_nxt = 1'b0;
      hs_mode_nxt  = 1'b0;
      if (radio_alive_r) begin
        radio_mode_nxt = 1'b1;
      end
    end else begin
      hs_alive_nxt   = 1'b1;
      link_block_nxt = 1'b0;
    end
    hs_cnt_nxt = sat_inc(hs_cnt0);

    // Radio failsafe
    radio_cnt_nxt = radio_cnt0;
    if (cfg.failsafe_enable) begin
      if (CMP_W'(radio_cnt0) > t_lost) begin
        radio_alive_nxt = 1'b0;
        radio_mode_nxt  = 1'b0;
        if (hs_alive_nxt) begin
          hs_mode_nxt = 1'b1;
          paused      = 1'b1;
        end else if (item.is_armed) begin
          ovr   = 1'b1;
          angle = item.accel_present;
          if (CMP_W'(radio_cnt0) > t_land) begin
            disarm         = 1'b1;
            link_block_nxt = 1'b1;
          end
        end else begin
          link_block_nxt = 1'b1;
        end
      end else begin
        radio_alive_nxt = 1'b1;
        link_block_nxt  = 1'b0;
      end
      if (!paused) begin
        radio_cnt_nxt = sat_inc(radio_cnt0);
      end
    end

    // Arming gate
    mask                 = '0;
    mask[MASK_LINK_LOST] = link_block_nxt;
    mask[MASK_UNCAL]     = !item.accel_calibrated;
    mask[MASK_CALIB]     = item.calibrating;
    mask[MASK_BUS_ERR]   = item.bus_error_count > BUS_LIM;

    result.radio_available      = radio_alive_nxt;
    result.radio_control_mode   = radio_mode_nxt;
    result.handset_available    = hs_alive_nxt;
    result.handset_control_mode = hs_mode_nxt;
    result.stick_override       = ovr;
    result.force_angle_mode     = angle;
    result.force_disarm         = disarm;
    result.arm_block_mask       = mask;
    result.arm_ok               = (mask == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radio_cnt_r   <= '0;
      hs_cnt_r      <= '0;
      radio_alive_r <= 1'b0;
      radio_mode_r  <= 1'b0;
      hs_alive_r    <= 1'b0;
      hs_mode_r     <= 1'b0;
      link_block_r  <= 1'b0;
    end else if (advance) begin
      radio_cnt_r   <= radio_cnt_nxt;
      hs_cnt_r      <= hs_cnt_nxt;
      radio_alive_r <= radio_alive_nxt;
      radio_mode_r  <= radio_mode_nxt;
      hs_alive_r    <= hs_alive_nxt;
      hs_mode_r     <= hs_mode_nxt;
      link_block_r  <= link_block_nxt;
    end
  end

endmodule

// ===== hw/rtl/link_loss_failsafe_supervisor.sv =====
// ----------------------------------------------------------------------------
// link_loss_failsafe_supervisor
// Radio and handset link supervision, failsafe landing and arming gate.
// ----------------------------------------------------------------------------
// One input transfer is one 20 ms tick. The tick is captured in an input
// register; once the output register is free, the handset supervisor, the
// radio failsafe and the arming gate are evaluated in one pass of short logic,
// the link state is updated and the result is written to the output register.
// Each tick therefore gives exactly one result transfer, and a new tick can
// be taken in every cycle unless the output side stalls: the input register
// can still take a tick while a finished result waits, and only a stalled,
// full output register with a full input register holds the input side. The
// five failsafe registers sit behind an APB port (4-byte spacing, pready tied
// high) and should be written only while no tick is in flight. The arm block
// mask reports: bit 0 link lost, bit 1 accelerometer not calibrated, bit 2
// calibration running, bit 3 bus error count above the limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module link_loss_failsafe_supervisor #(
  parameter int unsigned HANDSET_TIMEOUT_TICKS = llfs_pkg::HANDSET_TIMEOUT_DEF,
  parameter int unsigned TICKS_PER_DELAY_UNIT  = llfs_pkg::TICKS_PER_UNIT_DEF,
  parameter int unsigned BUS_ERROR_LIMIT       = llfs_pkg::BUS_ERROR_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Tick input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_radio_frame_seen,
  input  logic                            in_handset_frame_seen,
  input  logic                            in_is_armed,
  input  logic                            in_accel_present,
  input  logic                            in_accel_calibrated,
  input  logic                            in_calibrating,
  input  logic [llfs_pkg::BUS_W-1:0]      in_bus_error_count,
  // Result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_radio_available,
  output logic                            out_radio_control_mode,
  output logic                            out_handset_available,
  output logic                            out_handset_control_mode,
  output logic                            out_stick_override,
  output logic                            out_force_angle_mode,
  output logic                            out_force_disarm,
  output logic [llfs_pkg::MASK_W-1:0]     out_arm_block_mask,
  output logic                            out_arm_ok,
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [llfs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [llfs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [llfs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import llfs_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  result_t res_comb, res_r;
  logic    in_valid_r, in_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    in_accept, advance, out_free;

  llfs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Output register is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign in_valid_nxt  = in_accept || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the tick on an input transfer
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.radio_frame_seen   <= in_radio_frame_seen;
      item_r.handset_frame_seen <= in_handset_frame_seen;
      item_r.is_armed           <= in_is_armed;
      item_r.accel_present      <= in_accel_present;
      item_r.accel_calibrated   <= in_accel_calibrated;
      item_r.calibrating        <= in_calibrating;
      item_r.bus_error_count    <= in_bus_error_count;
    end
  end

  llfs_eval #(
    .HANDSET_TIMEOUT_TICKS (HANDSET_TIMEOUT_TICKS),
    .TICKS_PER_DELAY_UNIT  (TICKS_PER_DELAY_UNIT),
    .BUS_ERROR_LIMIT       (BUS_ERROR_LIMIT)
  ) u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res_comb)
  );

  // Hold the result while the output side stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_comb;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_radio_available      = res_r.radio_available;
  assign out_radio_control_mode   = res_r.radio_control_mode;
  assign out_handset_available    = res_r.handset_available;
  assign out_handset_control_mode = res_r.handset_control_mode;
  assign out_stick_override       = res_r.stick_override;
  assign out_force_angle_mode     = res_r.force_angle_mode;
  assign out_force_disarm         = res_r.force_disarm;
  assign out_arm_block_mask       = res_r.arm_block_mask;
  assign out_arm_ok               = res_r.arm_ok;

  // Input side waits only on a full, stalled output register
  `LLFS_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")
  // Disarm only ever comes with the landing override and the link-lost block
  `LLFS_ASSERT_IMPLY(a_disarm_override, out_valid && out_force_disarm, out_stick_override && out_arm_block_mask[MASK_LINK_LOST], "disarm without override or link-lost block")
  // Angle mode is forced only during the landing override
  `LLFS_ASSERT_IMPLY(a_angle_override, out_valid && out_force_angle_mode, out_stick_override, "angle mode forced outside failsafe override")
  // Handset control requires a live handset link
  `LLFS_ASSERT_IMPLY(a_handset_ctrl, out_valid && out_handset_control_mode, out_handset_available, "handset in control while its link is lost")

endmodule

// ===== test/link_loss_failsafe_supervisor_tb.sv =====
// ----------------------------------------------------------------------------
// link_loss_failsafe_supervisor_tb
// Self-checking bench for the link-loss failsafe supervisor. A short table of
// ticks opens the run, with some results typed in by hand. Random loss
// episodes follow under several register settings and handshake pressures,
// then an outage past the handset timeout under the longest radio timeouts.
// The remaining ticks are checked against an in-bench model of the link state.
// ----------------------------------------------------------------------------
module link_loss_failsafe_supervisor_tb;
  import llfs_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;   // cycles with no transfer at all
  localparam int unsigned FLUSH_CYCLES = 8;     // input and output registers plus margin

  // Register settings used by the phases
  localparam cfg_t QUICK_CFG   = '{1'b1, 8'd0, 8'd0, 12'd1500, 12'd1200};
  localparam cfg_t SHORT_CFG   = '{1'b1, 8'd2, 8'd3, 12'd0, 12'd4095};
  localparam cfg_t ZERO_CFG    = '{1'b1, 8'd0, 8'd0, 12'd4095, 12'd0};
  localparam cfg_t OFF_CFG     = '{1'b0, 8'd1, 8'd1, 12'd2048, 12'd2047};
  localparam cfg_t MIXED_CFG   = '{1'b1, 8'd1, 8'd4, 12'd1500, 12'd1200};
  localparam cfg_t NOMINAL_CFG = '{1'b1, 8'd10, 8'd6, 12'd100, 12'd200};
  localparam cfg_t LONG_CFG    = '{1'b1, 8'd255, 8'd255, 12'd4095, 12'd4095};

  // Directed rows before this index run with the reset register values
  localparam int DIR_RECONFIG_ROW = 5;

  typedef struct packed {
    logic    pinned;
    result_t status;
  } pin_t;

  typedef struct {
    item_t   tick;
    logic    pinned;
    result_t status;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_radio_frame_seen = 1'b0;
  logic                  in_handset_frame_seen = 1'b0;
  logic                  in_is_armed = 1'b0;
  logic                  in_accel_present = 1'b0;
  logic                  in_accel_calibrated = 1'b0;
  logic                  in_calibrating = 1'b0;
  logic [BUS_W-1:0]      in_bus_error_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_radio_available;
  logic                  out_radio_control_mode;
  logic                  out_handset_available;
  logic                  out_handset_control_mode;
  logic                  out_stick_override;
  logic                  out_force_angle_mode;
  logic                  out_force_disarm;
  logic [MASK_W-1:0]     out_arm_block_mask;
  logic                  out_arm_ok;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Model copy of the registers
  logic               fs_en;
  logic [DELAY_W-1:0] fs_dly;
  logic [DELAY_W-1:0] land_dly;
  logic [STICK_W-1:0] mid_val;
  logic [STICK_W-1:0] thr_val;

  // Model copy of the link state
  logic [LOSS_W-1:0] radio_miss;
  logic [LOSS_W-1:0] hs_miss;
  logic              radio_up;
  logic              radio_ctl;
  logic              hs_up;
  logic              hs_ctl;
  logic              arm_lock;

  result_t     status_due_q[$];   // predicted status per accepted tick, oldest first
  pin_t        pinned_q[$];       // hand-typed status per tick sent, oldest first
  dir_row_t    dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_pct = 0;      // chance in a hundred of an idle cycle before a tick
  int unsigned stall_pct = 0;     // chance in a hundred of stalling the status side

  link_loss_failsafe_supervisor dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Randomly hold off the status side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [LOSS_W-1:0] sat_bump(input logic [LOSS_W-1:0] c);
    return (c == {LOSS_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Advance the link state by one tick and return the status it produces.
  // Order matters: frame flags clear counters, then handset, radio, arming.
  function automatic result_t next_link_status(input item_t t);
    result_t     s;
    int unsigned lost_lim;
    int unsigned land_lim;
    logic        hold_radio;
    s = '0;
    if (t.radio_frame_seen) radio_miss = '0;
    if (t.handset_frame_seen) hs_miss = '0;

    if (hs_miss > HANDSET_TIMEOUT_DEF) begin
      hs_up = 1'b0;
      hs_ctl = 1'b0;
      if (radio_up) radio_ctl = 1'b1;
    end else begin
      hs_up = 1'b1;
      arm_lock = 1'b0;
    end
    hs_miss = sat_bump(hs_miss);

    if (fs_en) begin
      lost_lim = TICKS_PER_UNIT_DEF * int'(fs_dly);
      land_lim = TICKS_PER_UNIT_DEF * (int'(fs_dly) + int'(land_dly));
      hold_radio = 1'b0;
      if (int'(radio_miss) > lost_lim) begin
        radio_up = 1'b0;
        radio_ctl = 1'b0;
        if (hs_up) begin
          // handset takes over; radio counter pauses
          hs_ctl = 1'b1;
          hold_radio = 1'b1;
        end else if (t.is_armed) begin
          s.stick_override = 1'b1;
          s.force_angle_mode = t.accel_present;
          if (int'(radio_miss) > land_lim) begin
            s.force_disarm = 1'b1;
            arm_lock = 1'b1;
          end
        end else begin
          arm_lock = 1'b1;
        end
      end else begin
        radio_up = 1'b1;
        arm_lock = 1'b0;
      end
      if (!hold_radio) radio_miss = sat_bump(radio_miss);
    end

    s.arm_block_mask[MASK_LINK_LOST] = arm_lock;
    s.arm_block_mask[MASK_UNCAL]     = !t.accel_calibrated;
    s.arm_block_mask[MASK_CALIB]     = t.calibrating;
    s.arm_block_mask[MASK_BUS_ERR]   = (t.bus_error_count > BUS_ERROR_LIMIT_DEF);
    s.arm_ok               = (s.arm_block_mask == '0);
    s.radio_available      = radio_up;
    s.radio_control_mode   = radio_ctl;
    s.handset_available    = hs_up;
    s.handset_control_mode = hs_ctl;
    return s;
  endfunction

  function automatic void cmp_field(input string nm, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s: expected %0d, got %0d", $time, nm, want, got);
    end
  endfunction

  // Predict on every accepted tick; a hand-typed status replaces the prediction
  always @(posedge clk) begin : take_tick
    item_t   t;
    result_t s;
    pin_t    p;
    if (rst_n && in_valid && !in_stall) begin
      t = {in_radio_frame_seen, in_handset_frame_seen, in_is_armed, in_accel_present,
           in_accel_calibrated, in_calibrating, in_bus_error_count};
      s = next_link_status(t);
      if (pinned_q.size() != 0) begin
        p = pinned_q.pop_front();
        if (p.pinned) s = p.status;
      end
      status_due_q.push_back(s);
    end
  end

  // Check every accepted status transfer against the oldest prediction
  always @(posedge clk) begin : take_status
    result_t want;
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_radio_available, out_radio_control_mode, out_handset_available,
             out_handset_control_mode, out_stick_override, out_force_angle_mode,
             out_force_disarm, out_arm_block_mask, out_arm_ok};
      if (status_due_q.size() == 0) begin
        mismatches++;
        $display("%0t status transfer with none outstanding: %h", $time, got);
      end else begin
        want = status_due_q.pop_front();
        cmp_field("radio_available", want.radio_available, got.radio_available);
        cmp_field("radio_control_mode", want.radio_control_mode, got.radio_control_mode);
        cmp_field("handset_available", want.handset_available, got.handset_available);
        cmp_field("handset_control_mode", want.handset_control_mode,
                  got.handset_control_mode);
        cmp_field("stick_override", want.stick_override, got.stick_override);
        cmp_field("force_angle_mode", want.force_angle_mode, got.force_angle_mode);
        cmp_field("force_disarm", want.force_disarm, got.force_disarm);
        cmp_field("arm_block_mask", want.arm_block_mask, got.arm_block_mask);
        cmp_field("arm_ok", want.arm_ok, got.arm_ok);
      end
    end
  end

  // Offer one tick and hold it until it is taken
  task automatic send_tick(input item_t t, input logic pin, input result_t s);
    pinned_q.push_back('{pin, s});
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_radio_frame_seen   <= t.radio_frame_seen;
    in_handset_frame_seen <= t.handset_frame_seen;
    in_is_armed           <= t.is_armed;
    in_accel_present      <= t.accel_present;
    in_accel_calibrated   <= t.accel_calibrated;
    in_calibrating        <= t.calibrating;
    in_bus_error_count    <= t.bus_error_count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted status has been transferred
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (status_due_q.size() != 0);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FS_ENABLE:   fs_en    = val[0];
      REG_FS_DELAY:    fs_dly   = val[DELAY_W-1:0];
      REG_LAND_DELAY:  land_dly = val[DELAY_W-1:0];
      REG_MID_STICK:   mid_val  = val[STICK_W-1:0];
      REG_FS_THROTTLE: thr_val  = val[STICK_W-1:0];
      default: ;   // unmapped slot: nothing changes
    endcase
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [REG_IDX_W-1:0] idx, output logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read back every register and compare with the model copy
  task automatic check_regs();
    logic [APB_DATA_W-1:0] got;
    logic [APB_DATA_W-1:0] want;
    for (int i = REG_FS_ENABLE; i <= REG_FS_THROTTLE; i++) begin
      apb_read(REG_IDX_W'(i), got);
      case (REG_IDX_W'(i))
        REG_FS_ENABLE:   want = APB_DATA_W'(fs_en);
        REG_FS_DELAY:    want = APB_DATA_W'(fs_dly);
        REG_LAND_DELAY:  want = APB_DATA_W'(land_dly);
        REG_MID_STICK:   want = APB_DATA_W'(mid_val);
        default:         want = APB_DATA_W'(thr_val);
      endcase
      cmp_field("register readback", want, got);
    end
  endtask

  // Reprogram the block once it is idle. Writes to the unmapped slots above
  // the last register must leave everything untouched.
  task automatic apply_cfg(input cfg_t c);
    hold_until_drained();
    repeat (FLUSH_CYCLES) @(posedge clk);
    apb_write(REG_FS_ENABLE, APB_DATA_W'(c.failsafe_enable));
    apb_write(REG_FS_DELAY, APB_DATA_W'(c.loss_delay));
    apb_write(REG_LAND_DELAY, APB_DATA_W'(c.landing_delay));
    apb_write(REG_MID_STICK, APB_DATA_W'(c.mid_stick));
    apb_write(REG_FS_THROTTLE, APB_DATA_W'(c.land_throttle));
    for (int i = REG_FS_THROTTLE + 1; i < 2 ** REG_IDX_W; i++) begin
      apb_write(REG_IDX_W'(i), $urandom);
    end
    check_regs();
  endtask

  function automatic item_t tick_of(input logic rf, input logic hf, input logic arm,
                                    input logic ap, input logic ac, input logic cal,
                                    input logic [BUS_W-1:0] bus);
    return {rf, hf, arm, ap, ac, cal, bus};
  endfunction

  function automatic result_t status_of(input logic ra, input logic rm, input logic ha,
                                        input logic hm, input logic so, input logic fa,
                                        input logic fd, input logic [MASK_W-1:0] mask,
                                        input logic ok);
    return {ra, rm, ha, hm, so, fa, fd, mask, ok};
  endfunction

  // Random tick, accelerometer calibrated three times in four; bus errors cluster around the limit half the time
  function automatic item_t noise_tick();
    logic [31:0] r;
    item_t       t;
    r = $urandom;
    t = r[$bits(item_t)-1:0];
    t.accel_calibrated = ($urandom_range(3) != 0);
    if ($urandom_range(1) != 0) t.bus_error_count = BUS_W'($urandom_range(110, 90));
    return t;
  endfunction

  // Loss episodes: runs of ticks with few radio frames whose length straddles
  // the loss and landing thresholds, with the handset either chattering or
  // silent, then a short recovery. One episode in five is plain noise.
  task automatic run_episodes(input int unsigned quota);
    int unsigned sent;
    int unsigned run_len;
    logic        hs_chatty;
    logic        ep_armed;
    logic        ep_noise;
    item_t       t;
    sent = 0;
    while (sent < quota) begin
      run_len   = $urandom_range(5 * (int'(fs_dly) + int'(land_dly)) + 80, 1);
      hs_chatty = ($urandom_range(2) == 0);
      ep_armed  = ($urandom_range(3) != 0);
      ep_noise  = ($urandom_range(4) == 0);
      for (int k = 0; k < run_len; k++) begin
        t = noise_tick();
        if (!ep_noise) begin
          t.radio_frame_seen   = ($urandom_range(39) == 0);
          t.handset_frame_seen = hs_chatty && ($urandom_range(3) != 0);
          t.is_armed           = ($urandom_range(29) == 0) ? !ep_armed : ep_armed;
        end
        send_tick(t, 1'b0, '0);
      end
      repeat ($urandom_range(4, 1)) begin
        t = noise_tick();
        t.radio_frame_seen = 1'b1;
        send_tick(t, 1'b0, '0);
      end
      sent += run_len;
      if ($urandom_range(7) == 0) hold_until_drained();
    end
  endtask

  function automatic void load_dir_rows();
    result_t nominal;
    nominal = status_of(1, 0, 1, 0, 0, 0, 0, 4'h0, 1);
    // Reset register values: both links fresh, only the arming inputs matter
    dir_rows.push_back('{tick_of(1, 1, 0, 0, 1, 0, 16'h0000), 1'b1, nominal});
    dir_rows.push_back('{tick_of(1, 1, 0, 0, 1, 0, 16'h0064), 1'b1, nominal});
    dir_rows.push_back('{tick_of(1, 1, 0, 0, 1, 0, 16'h0065), 1'b1,
                         status_of(1, 0, 1, 0, 0, 0, 0, 4'h8, 0)});
    dir_rows.push_back('{tick_of(1, 1, 1, 1, 0, 1, 16'hFFFF), 1'b1,
                         status_of(1, 0, 1, 0, 0, 0, 0, 4'hE, 0)});
    dir_rows.push_back('{tick_of(0, 0, 0, 0, 1, 0, 16'h0000), 1'b1, nominal});
    // Zero delays: one missed radio frame loses the link, handset takes over
    dir_rows.push_back('{tick_of(1, 1, 1, 1, 1, 0, 16'h0000), 1'b0, '0});
    dir_rows.push_back('{tick_of(0, 1, 1, 1, 1, 0, 16'h0064), 1'b0, '0});
    dir_rows.push_back('{tick_of(0, 0, 1, 1, 1, 0, 16'h0065), 1'b0, '0});
    dir_rows.push_back('{tick_of(1, 0, 0, 0, 1, 1, 16'hFFFF), 1'b0, '0});
    dir_rows.push_back('{tick_of(0, 0, 0, 0, 0, 0, 16'h8000), 1'b0, '0});
    dir_rows.push_back('{tick_of(0, 1, 1, 0, 1, 0, 16'h7FFF), 1'b0, '0});
    dir_rows.push_back('{tick_of(1, 1, 0, 1, 0, 1, 16'h5555), 1'b0, '0});
    dir_rows.push_back('{tick_of(0, 0, 1, 1, 1, 0, 16'hAAAA), 1'b0, '0});
    dir_rows.push_back('{tick_of(1, 1, 1, 1, 1, 1, 16'hFFFF), 1'b0, '0});
    dir_rows.push_back('{tick_of(0, 0, 0, 0, 0, 0, 16'h0000), 1'b0, '0});
  endfunction

  initial begin : stimulus
    item_t t;
    fs_en      = RST_FS_ENABLE;
    fs_dly     = RST_FS_DELAY;
    land_dly   = RST_LAND_DELAY;
    mid_val    = RST_MID_STICK;
    thr_val    = RST_FS_THROTTLE;
    radio_miss = '0;
    hs_miss    = '0;
    radio_up   = 1'b0;
    radio_ctl  = 1'b0;
    hs_up      = 1'b0;
    hs_ctl     = 1'b0;
    arm_lock   = 1'b0;
    load_dir_rows();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_regs();

    // Directed table, switching to zero delays part way through
    for (int r = 0; r < dir_rows.size(); r++) begin
      if (r == DIR_RECONFIG_ROW) apply_cfg(QUICK_CFG);
      send_tick(dir_rows[r].tick, dir_rows[r].pinned, dir_rows[r].status);
    end

    // Random episodes under each handshake pressure
    apply_cfg(SHORT_CFG);
    run_episodes(300);

    apply_cfg(ZERO_CFG);
    send_pct = 80;
    run_episodes(300);

    apply_cfg(OFF_CFG);
    send_pct  = 0;
    stall_pct = 80;
    run_episodes(300);

    apply_cfg(MIXED_CFG);
    send_pct  = 13;
    stall_pct = 13;
    run_episodes(150);
    hold_until_drained();
    run_episodes(150);

    apply_cfg(NOMINAL_CFG);
    run_episodes(300);

    // Longest timeouts, then an outage that loses the handset but not the radio
    apply_cfg(LONG_CFG);
    send_pct  = 0;
    stall_pct = 0;
    repeat (2) begin
      t = noise_tick();
      t.radio_frame_seen   = 1'b1;
      t.handset_frame_seen = 1'b1;
      send_tick(t, 1'b0, '0);
    end
    repeat (200) begin
      t = noise_tick();
      t.radio_frame_seen   = 1'b0;
      t.handset_frame_seen = 1'b0;
      t.is_armed           = ($urandom_range(7) != 0);
      send_tick(t, 1'b0, '0);
    end
    repeat (20) begin
      t = noise_tick();
      t.radio_frame_seen   = 1'b1;
      t.handset_frame_seen = 1'b1;
      send_tick(t, 1'b0, '0);
    end

    // Drain, let the pipeline settle, then report
    hold_until_drained();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (status_due_q.size() != 0) begin
      mismatches++;
      $display("%0t %0d status transfers never arrived", $time, status_due_q.size());
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
